// ===== rtl/ptdt_pkg.sv =====
package ptdt_pkg;

  localparam int MAX_TASKS = 8;
  localparam int TIME_BITS = 32;

  localparam int ID_W     = 4;
  localparam int PERIOD_W = 32;
  localparam int START_W  = 32;
  localparam int ACTION_W = 3;
  localparam int KIND_W   = 2;
  localparam int STAT_W   = 2;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int NF_W  = $clog2(MAX_TASKS + 1);
  localparam int CMP_W = (TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W;

  // stream word widths, padded to whole bytes
  localparam int IN_FIELDS_W  = ID_W + START_W + PERIOD_W + 2;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_USER_W    = 8;
  localparam int OUT_FIELDS_W = ID_W + STAT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_USER_W   = 8;

  localparam logic [ACTION_W-1:0] ACT_TICK       = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_CREATE     = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SET_STATUS = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_GET_STATUS = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SET_TIMERS = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_SCAN       = 3'd5;

  localparam logic [KIND_W-1:0] KIND_ACK      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CREATED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd3;

  localparam logic [STAT_W-1:0] STAT_IDLE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_READY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDEF = 2'd2;

  typedef struct packed {
    logic [IDX_W-1:0]     slot;
    logic                 wr_start;
    logic [TIME_BITS-1:0] start;
    logic                 wr_period;
    logic [PERIOD_W-1:0]  period;
    logic                 wr_ready;
    logic                 ready;
    logic                 wr_periodic;
    logic                 periodic;
  } slot_wr_t;

  typedef struct packed {
    logic                 ready;
    logic                 periodic;
    logic [TIME_BITS-1:0] start;
    logic [PERIOD_W-1:0]  period;
  } slot_rd_t;

endpackage

// ===== rtl/ptdt_due_unit.sv =====
module ptdt_due_unit (
  input  logic [ptdt_pkg::TIME_BITS-1:0] now_i,
  input  logic [ptdt_pkg::TIME_BITS-1:0] start_i,
  input  logic [ptdt_pkg::PERIOD_W-1:0]  period_i,
  output logic                           due_o
);
  import ptdt_pkg::*;

  logic [TIME_BITS-1:0] elapsed;

  // wraps modulo 2^TIME_BITS
  assign elapsed = now_i - start_i;
  assign due_o   = CMP_W'(elapsed) >= CMP_W'(period_i);

endmodule

// ===== rtl/ptdt_slot_table.sv =====
module ptdt_slot_table (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  ptdt_pkg::slot_wr_t    wr_i,
  input  logic [ptdt_pkg::IDX_W-1:0] rd_slot_i,
  output ptdt_pkg::slot_rd_t    rd_o
);
  import ptdt_pkg::*;

  logic [TIME_BITS-1:0] start_q  [MAX_TASKS];
  logic [PERIOD_W-1:0]  period_q [MAX_TASKS];
  logic [MAX_TASKS-1:0] ready_q;
  logic [MAX_TASKS-1:0] periodic_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        start_q[i]  <= '0;
        period_q[i] <= '0;
      end
      ready_q    <= '0;
      periodic_q <= '0;
    end else if (we_i) begin
      if (wr_i.wr_start)    start_q[wr_i.slot]    <= wr_i.start;
      if (wr_i.wr_period)   period_q[wr_i.slot]   <= wr_i.period;
      if (wr_i.wr_ready)    ready_q[wr_i.slot]    <= wr_i.ready;
      if (wr_i.wr_periodic) periodic_q[wr_i.slot] <= wr_i.periodic;
    end
  end

  assign rd_o.ready    = ready_q[rd_slot_i];
  assign rd_o.periodic = periodic_q[rd_slot_i];
  assign rd_o.start    = start_q[rd_slot_i];
  assign rd_o.period   = period_q[rd_slot_i];

endmodule

// ===== rtl/periodic_task_dispatch_table.sv =====
// Tick, create, set status, get status and set timers: the result register is
// loaded on accept, and a new command is taken once the output is free again.
// Scan: the sequencer runs each slot through the shared due compare, one slot
// per cycle while the output is free, then emits a closing ack with tlast set.
// Asynchronous active-low reset clears the slot table, time and free pointer.
module periodic_task_dispatch_table (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // task_id[3:0], start_time[35:4], period[67:36], periodic[68], status_in[69]
  input  logic [ptdt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // action[2:0]
  input  logic [ptdt_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // task_id_out[3:0], status_out[5:4]
  output logic [ptdt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // kind[1:0]
  output logic [ptdt_pkg::OUT_USER_W-1:0]    m_axis_tuser,
  output logic                               m_axis_tlast
);
  import ptdt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_ACK  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [NF_W-1:0]      nf_q, nf_d;
  logic [TIME_BITS-1:0] time_q, time_d;

  logic                 out_v_q;
  logic [KIND_W-1:0]    out_kind_q;
  logic [ID_W-1:0]      out_id_q;
  logic [STAT_W-1:0]    out_stat_q;
  logic                 out_last_q;

  logic [ACTION_W-1:0]  action;
  logic [ID_W-1:0]      task_id;
  logic [START_W-1:0]   start_time;
  logic [PERIOD_W-1:0]  period;
  logic                 periodic;
  logic                 status_in;

  logic                 accept, out_free, id_ok, full, due;
  logic [IDX_W-1:0]     id_slot, rd_slot;
  logic                 we;
  slot_wr_t             wr;
  slot_rd_t             rd;

  logic                 emit, e_last;
  logic [KIND_W-1:0]    e_kind;
  logic [ID_W-1:0]      e_id;
  logic [STAT_W-1:0]    e_stat;

  assign action     = s_axis_tuser[ACTION_W-1:0];
  assign task_id    = s_axis_tdata[ID_W-1:0];
  assign start_time = s_axis_tdata[ID_W +: START_W];
  assign period     = s_axis_tdata[ID_W+START_W +: PERIOD_W];
  assign periodic   = s_axis_tdata[ID_W+START_W+PERIOD_W];
  assign status_in  = s_axis_tdata[ID_W+START_W+PERIOD_W+1];

  assign out_free      = !out_v_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign id_ok   = (task_id != '0) && (32'(task_id) <= 32'(MAX_TASKS));
  assign id_slot = IDX_W'(task_id - ID_W'(1));
  assign full    = (nf_q == NF_W'(MAX_TASKS));
  assign rd_slot = (state_q == S_IDLE) ? id_slot : idx_q;

  ptdt_slot_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (we),
    .wr_i      (wr),
    .rd_slot_i (rd_slot),
    .rd_o      (rd)
  );

  ptdt_due_unit u_due (
    .now_i    (time_q),
    .start_i  (rd.start),
    .period_i (rd.period),
    .due_o    (due)
  );

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    nf_d    = nf_q;
    time_d  = time_q;
    we      = 1'b0;
    wr      = '0;
    emit    = 1'b0;
    e_kind  = KIND_ACK;
    e_id    = '0;
    e_stat  = STAT_IDLE;
    e_last  = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (action)
            ACT_TICK: begin
              time_d = time_q + TIME_BITS'(1);
              emit   = 1'b1;
            end
            ACT_CREATE: begin
              emit   = 1'b1;
              e_kind = KIND_CREATED;
              if (!full) begin
                we             = 1'b1;
                wr.slot        = nf_q[IDX_W-1:0];
                wr.wr_start    = 1'b1;
                wr.start       = TIME_BITS'(start_time);
                wr.wr_period   = 1'b1;
                wr.period      = period;
                wr.wr_periodic = 1'b1;
                wr.periodic    = periodic;
                nf_d           = nf_q + NF_W'(1);
                e_id           = ID_W'(32'(nf_q) + 32'd1);
              end
            end
            ACT_SET_STATUS: begin
              emit = 1'b1;
              if (id_ok) begin
                we          = 1'b1;
                wr.slot     = id_slot;
                wr.wr_ready = 1'b1;
                wr.ready    = status_in;
                wr.wr_start = status_in;
                wr.start    = time_q;
              end
            end
            ACT_GET_STATUS: begin
              emit   = 1'b1;
              e_kind = KIND_STATUS;
              e_stat = id_ok ? (rd.ready ? STAT_READY : STAT_IDLE) : STAT_UNDEF;
            end
            ACT_SET_TIMERS: begin
              emit = 1'b1;
              if (id_ok) begin
                we           = 1'b1;
                wr.slot      = id_slot;
                wr.wr_start  = (start_time != '0);
                wr.start     = TIME_BITS'(start_time);
                wr.wr_period = (period != '0);
                wr.period    = period;
              end
            end
            ACT_SCAN: begin
              state_d = S_SCAN;
              idx_d   = '0;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (out_free) begin
          if (rd.ready && due) begin
            // restamp; one-shot tasks drop back to idle
            we          = 1'b1;
            wr.slot     = idx_q;
            wr.wr_start = 1'b1;
            wr.start    = time_q;
            wr.wr_ready = !rd.periodic;
            wr.ready    = 1'b0;
            emit        = 1'b1;
            e_kind      = KIND_DISPATCH;
            e_id        = ID_W'(32'(idx_q) + 32'd1);
            e_stat      = rd.periodic ? STAT_READY : STAT_IDLE;
            e_last      = 1'b0;
          end
          if (32'(idx_q) == 32'(MAX_TASKS - 1)) begin
            state_d = S_ACK;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      S_ACK: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      nf_q    <= '0;
      time_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      nf_q    <= nf_d;
      time_q  <= time_d;
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q <= e_kind;
      out_id_q   <= e_id;
      out_stat_q <= e_stat;
      out_last_q <= e_last;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_stat_q, out_id_q});
  assign m_axis_tuser  = OUT_USER_W'(out_kind_q);
  assign m_axis_tlast  = out_last_q;

endmodule
